>>> sv/ndd_pkg.sv
`default_nettype none
package ndd_pkg;

	localparam int LINEAGE_W   = 16;
	localparam int RATIO_W     = 16;
	localparam int LIMIT_W     = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [RATIO_W-1:0] RATIO_RESET  = 16'd256;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 4'd8;
	localparam logic [LIMIT_W-1:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RATIO        = 2'd0,
		CFG_MAX_REPORTED = 2'd1,
		CFG_ACTIVE_GENES = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic                 valid;
		logic                 first;
		logic [LINEAGE_W-1:0] lineage;
	} side_t;

endpackage
`default_nettype wire

>>> sv/ndd_sqdiff.sv
`default_nettype none
module ndd_sqdiff #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         adv,
	input  wire logic [SAMPLE_BITS-1:0]       now,
	input  wire logic [SAMPLE_BITS-1:0]       prev,
	output logic      [2*SAMPLE_BITS+1:0]     sq_s2
);

	logic [SAMPLE_BITS:0] diff;
	logic [SAMPLE_BITS:0] mag;
	logic [SAMPLE_BITS:0] mag_s1;

	assign diff = {now[SAMPLE_BITS-1], now} - {prev[SAMPLE_BITS-1], prev};
	assign mag  = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag;
			sq_s2  <= mag_s1 * mag_s1;
		end
	end

endmodule
`default_nettype wire

>>> sv/ndd_merge.sv
`default_nettype none
module ndd_merge #(
	parameter int GENE_LANES  = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int SQW = 2 * SAMPLE_BITS + 2,
	localparam int PW  = SQW + ndd_pkg::RATIO_W,
	localparam int CW  = $clog2(GENE_LANES + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire ndd_pkg::side_t                      side_s2,
	input  wire logic [SQW-1:0]                      u_sq_s2,
	input  wire logic [GENE_LANES-1:0][SQW-1:0]      g_sq_s2,
	input  wire logic [ndd_pkg::RATIO_W-1:0]         ratio,
	input  wire logic [ndd_pkg::LIMIT_W-1:0]         max_reported,
	input  wire logic [GENE_LANES-1:0]               lane_on,
	output logic                                     out_valid,
	output logic      [ndd_pkg::LINEAGE_W-1:0]       out_lineage,
	output logic      [GENE_LANES-1:0]               out_mask,
	output logic      [CW-1:0]                       out_count
);

	localparam int CMPW = (CW > ndd_pkg::LIMIT_W) ? CW : ndd_pkg::LIMIT_W;

	ndd_pkg::side_t                 side_s3;
	ndd_pkg::side_t                 side_s4;
	logic [PW-1:0]                  u_prod_s3;
	logic [GENE_LANES-1:0][SQW-1:0] g_sq_s3;
	logic [GENE_LANES-1:0]          hit;
	logic [GENE_LANES-1:0]          mask_s4;
	logic [CW-1:0]                  count;
	logic                           count_ok;

	always_comb begin
		for (int k = 0; k < GENE_LANES; k++) begin
			hit[k] = lane_on[k] &&
				({{(PW-SQW-8){1'b0}}, g_sq_s3[k], 8'b0} > u_prod_s3);
		end
	end

	always_comb begin
		count = '0;
		for (int k = 0; k < GENE_LANES; k++) begin
			count = count + CW'(mask_s4[k]);
		end
	end

	assign count_ok = CMPW'(count) <= CMPW'(max_reported);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3   <= '0;
			side_s4   <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			side_s3   <= side_s2;
			side_s4   <= side_s3;
			out_valid <= side_s4.valid && !side_s4.first && count_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_prod_s3       <= ratio * u_sq_s2;
			g_sq_s3         <= g_sq_s2;
			mask_s4         <= hit;
			out_lineage     <= side_s4.lineage;
			out_mask        <= mask_s4;
			out_count       <= count;
		end
	end

endmodule
`default_nettype wire

>>> sv/neighbour_diff_dominance_mask.sv
// Takes one nucleus record per item and, against the record before it, marks every
// active component whose squared change exceeds ratio/256 times u's squared change;
// the mask, its count and the lineage come out when the count is within max_reported,
// and first-of-set records give nothing. One item is accepted every cycle unless
// the output is stalled; results pass s1 to s4 and the output register. All lanes and
// the output register advance together, so a stall on the master side holds s_tready
// low until the waiting result is taken. Configuration writes are always ready.
`default_nettype none
module neighbour_diff_dominance_mask #(
	parameter int GENE_LANES  = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int CW     = $clog2(GENE_LANES + 1),
	localparam int IN_W   = ndd_pkg::LINEAGE_W + SAMPLE_BITS * (GENE_LANES + 1),
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = ndd_pkg::LINEAGE_W + GENE_LANES + CW,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// lineage, u_level, gene_0 .. gene_N
	input  wire logic [IN_TW-1:0]                  s_tdata,
	// first_of_set
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// out_lineage, dominant_mask, dominant_count
	output logic      [OUT_TW-1:0]                 m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ndd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ndd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SQW = 2 * SAMPLE_BITS + 2;
	localparam int LW  = ndd_pkg::LINEAGE_W;

	logic [ndd_pkg::RATIO_W-1:0]     ratio_q;
	logic [ndd_pkg::LIMIT_W-1:0]     max_reported_q;
	logic [ndd_pkg::LIMIT_W-1:0]     active_genes_q;
	logic [SAMPLE_BITS-1:0]          prev_u_q;
	logic [GENE_LANES-1:0][SAMPLE_BITS-1:0] prev_genes_q;
	logic [GENE_LANES-1:0][SAMPLE_BITS-1:0] genes_now;
	logic [SAMPLE_BITS-1:0]          u_now;
	logic                            adv;
	logic                            accept;
	ndd_pkg::side_t                  side_s1;
	ndd_pkg::side_t                  side_s2;
	logic [SQW-1:0]                  u_sq_s2;
	logic [GENE_LANES-1:0][SQW-1:0]  g_sq_s2;
	logic [GENE_LANES-1:0]           lane_on;
	logic                            out_valid;
	logic [LW-1:0]                   out_lineage;
	logic [GENE_LANES-1:0]           out_mask;
	logic [CW-1:0]                   out_count;

	assign adv       = !out_valid || m_tready;
	assign s_tready  = adv;
	assign accept    = s_tvalid && adv;
	assign cfg_ready = 1'b1;
	assign u_now     = s_tdata[LW +: SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q        <= ndd_pkg::RATIO_RESET;
			max_reported_q <= ndd_pkg::LIMIT_RESET;
			active_genes_q <= ndd_pkg::ACTIVE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ndd_pkg::CFG_RATIO: begin
					ratio_q <= cfg_data[ndd_pkg::RATIO_W-1:0];
				end
				ndd_pkg::CFG_MAX_REPORTED: begin
					max_reported_q <= cfg_data[ndd_pkg::LIMIT_W-1:0];
				end
				ndd_pkg::CFG_ACTIVE_GENES: begin
					active_genes_q <= cfg_data[ndd_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_u_q     <= '0;
			prev_genes_q <= '0;
		end else if (accept) begin
			prev_u_q     <= u_now;
			prev_genes_q <= genes_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
		end else if (adv) begin
			side_s1.valid   <= s_tvalid;
			side_s1.first   <= s_tuser;
			side_s1.lineage <= s_tdata[LW-1:0];
			side_s2         <= side_s1;
		end
	end

	ndd_sqdiff #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_u (
		.clk   (clk),
		.adv   (adv),
		.now   (u_now),
		.prev  (prev_u_q),
		.sq_s2 (u_sq_s2)
	);

	for (genvar k = 0; k < GENE_LANES; k++) begin : g_lane
		assign genes_now[k] = s_tdata[LW + SAMPLE_BITS * (k + 1) +: SAMPLE_BITS];
		assign lane_on[k]   = active_genes_q > ndd_pkg::LIMIT_W'(k);

		ndd_sqdiff #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_g (
			.clk   (clk),
			.adv   (adv),
			.now   (genes_now[k]),
			.prev  (prev_genes_q[k]),
			.sq_s2 (g_sq_s2[k])
		);
	end

	ndd_merge #(
		.GENE_LANES  (GENE_LANES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.side_s2      (side_s2),
		.u_sq_s2      (u_sq_s2),
		.g_sq_s2      (g_sq_s2),
		.ratio        (ratio_q),
		.max_reported (max_reported_q),
		.lane_on      (lane_on),
		.out_valid    (out_valid),
		.out_lineage  (out_lineage),
		.out_mask     (out_mask),
		.out_count    (out_count)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = OUT_TW'({out_count, out_mask, out_lineage});

	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones(out_mask) == int'(out_count)))
		else $error("dominant count does not match the mask");

	a_no_inactive_lane: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((out_mask >> active_genes_q) == '0))
		else $error("an inactive lane is marked dominant");

	a_count_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(out_count) <= int'(max_reported_q)))
		else $error("an item over the reporting limit was delivered");

endmodule
`default_nettype wire
